// ===== hdl/bsft_pkg.sv =====
package bsft_pkg;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_DATA  = 2'd1,
    OP_END   = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    REG_START_BYTE  = 3'd0,
    REG_END_BYTE    = 3'd1,
    REG_ESCAPE_BYTE = 3'd2,
    REG_START_SUB   = 3'd3,
    REG_END_SUB     = 3'd4,
    REG_ESCAPE_SUB  = 3'd5
  } reg_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CheckW = 7;

  localparam logic [7:0] RstStartByte  = 8'h02;
  localparam logic [7:0] RstEndByte    = 8'h03;
  localparam logic [7:0] RstEscapeByte = 8'h1b;
  localparam logic [7:0] RstStartSub   = 8'he7;
  localparam logic [7:0] RstEndSub     = 8'he8;
  localparam logic [7:0] RstEscapeSub  = 8'h00;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] value;
    logic       raw_mode;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] escape_byte;
    logic [7:0] start_sub;
    logic [7:0] end_sub;
    logic [7:0] escape_sub;
  } cfg_t;

  // one queued job: up to three bytes, sent from index 0 upward
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            frame_end;
  } job_t;

  typedef struct packed {
    logic       esc;
    logic [7:0] first;
    logic [7:0] second;
  } stuff_t;

  // first match wins: start, then end, then escape
  function automatic stuff_t stuff_byte(logic [7:0] b, logic raw, cfg_t cfg);
    stuff_t s;
    s.esc = 1'b0;
    s.first = b;
    s.second = 8'h00;
    if (!raw) begin
      if (b == cfg.start_byte) begin
        s.esc = 1'b1;
        s.first = cfg.escape_byte;
        s.second = cfg.start_sub;
      end else if (b == cfg.end_byte) begin
        s.esc = 1'b1;
        s.first = cfg.escape_byte;
        s.second = cfg.end_sub;
      end else if (b == cfg.escape_byte) begin
        s.esc = 1'b1;
        s.first = cfg.escape_byte;
        s.second = cfg.escape_sub;
      end
    end
    return s;
  endfunction

endpackage

// ===== hdl/bsft_front.sv =====
module bsft_front import bsft_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  in_item_t            item_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                job_valid_o,
  output job_t                job_o
);

  cfg_t              cfg_q, cfg_d;
  logic              in_frame_q, in_frame_d;
  logic              raw_q, raw_d;
  logic [CheckW-1:0] check_q, check_d;
  stuff_t            st_tag, st_data, st_chk;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_START_BYTE:  cfg_d.start_byte = cfg_wdata_i;
        REG_END_BYTE:    cfg_d.end_byte = cfg_wdata_i;
        REG_ESCAPE_BYTE: cfg_d.escape_byte = cfg_wdata_i;
        REG_START_SUB:   cfg_d.start_sub = cfg_wdata_i;
        REG_END_SUB:     cfg_d.end_sub = cfg_wdata_i;
        REG_ESCAPE_SUB:  cfg_d.escape_sub = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign st_tag = stuff_byte(item_i.value, item_i.raw_mode, cfg_q);
  assign st_data = stuff_byte(item_i.value, raw_q, cfg_q);
  assign st_chk = stuff_byte({1'b0, check_q}, raw_q, cfg_q);

  always_comb begin
    in_frame_d = in_frame_q;
    raw_d = raw_q;
    check_d = check_q;
    job_valid_o = 1'b0;
    job_o = '0;
    if (accept_i) begin
      case (item_i.operation)
        OP_START: begin
          job_valid_o = 1'b1;
          in_frame_d = 1'b1;
          raw_d = item_i.raw_mode;
          check_d = item_i.value[CheckW-1:0];
          job_o.bytes[0] = cfg_q.start_byte;
          job_o.bytes[1] = st_tag.first;
          job_o.bytes[2] = st_tag.second;
          job_o.cnt = st_tag.esc ? 2'd3 : 2'd2;
        end
        OP_DATA: begin
          if (in_frame_q) begin
            job_valid_o = 1'b1;
            check_d = check_q ^ item_i.value[CheckW-1:0];
            job_o.bytes[0] = st_data.first;
            job_o.bytes[1] = st_data.second;
            job_o.cnt = st_data.esc ? 2'd2 : 2'd1;
          end
        end
        OP_END: begin
          if (in_frame_q) begin
            job_valid_o = 1'b1;
            in_frame_d = 1'b0;
            job_o.frame_end = 1'b1;
            job_o.bytes[0] = st_chk.first;
            if (st_chk.esc) begin
              job_o.bytes[1] = st_chk.second;
              job_o.bytes[2] = cfg_q.end_byte;
              job_o.cnt = 2'd3;
            end else begin
              job_o.bytes[1] = cfg_q.end_byte;
              job_o.cnt = 2'd2;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte <= RstStartByte;
      cfg_q.end_byte <= RstEndByte;
      cfg_q.escape_byte <= RstEscapeByte;
      cfg_q.start_sub <= RstStartSub;
      cfg_q.end_sub <= RstEndSub;
      cfg_q.escape_sub <= RstEscapeSub;
      in_frame_q <= 1'b0;
      raw_q <= 1'b0;
      check_q <= '0;
    end else begin
      cfg_q <= cfg_d;
      in_frame_q <= in_frame_d;
      raw_q <= raw_d;
      check_q <= check_d;
    end
  end

endmodule

// ===== hdl/bsft_queue.sv =====
module bsft_queue import bsft_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_en_i,
  input  job_t wdata_i,
  input  logic rd_en_i,
  output job_t rdata_o,
  output logic full_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o = cnt_q == CntW'(Depth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({wr_en_i, rd_en_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/bsft_back.sv =====
module bsft_back import bsft_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  job_t      q_data_i,
  output logic      q_rd_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  logic       valid_q;
  logic [1:0] idx_q;
  job_t       job_q;
  logic       last;
  logic       pop_ok;
  logic       load;

  assign last = idx_q == (job_q.cnt - 2'd1);
  assign pop_ok = pop_i && valid_q;
  // take the next job once the current one has gone out completely
  assign load = !valid_q || (pop_ok && last);
  assign q_rd_o = load && !q_empty_i;
  assign empty_o = !valid_q;

  always_comb begin
    case (idx_q)
      2'd1:    out_item_o.out_byte = job_q.bytes[1];
      2'd2:    out_item_o.out_byte = job_q.bytes[2];
      default: out_item_o.out_byte = job_q.bytes[0];
    endcase
    out_item_o.run_last = last;
    out_item_o.frame_done = last && job_q.frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q <= '0;
    end else if (load) begin
      valid_q <= !q_empty_i;
      idx_q <= '0;
    end else if (pop_ok) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      job_q <= q_data_i;
    end
  end

endmodule

// ===== hdl/byte_stuffing_frame_transmitter_core.sv =====
// output path: the first output byte of an accepted word passes through the job queue
// and the serializer's job register before it is on the result ports and can be popped
// throughput: one output byte per cycle from the back-end serializer while pop is held;
// an item gives up to three bytes; items enter one per cycle while the job queue has room
// reset: rst_ni clears frame state, checksum, queue and serializer and loads the
// default delimiter and substitute bytes
module byte_stuffing_frame_transmitter_core import bsft_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  in_item_t            in_item_i,
  output logic                empty,
  input  logic                pop,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  logic accept;
  logic job_valid;
  job_t job;
  job_t q_data;
  logic q_rd;
  logic q_empty;

  assign accept = push && !full;

  bsft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  bsft_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (job_valid),
    .wdata_i (job),
    .rd_en_i (q_rd),
    .rdata_o (q_data),
    .full_o  (full),
    .empty_o (q_empty)
  );

  bsft_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_data),
    .q_rd_o     (q_rd),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule

// ===== hdl/bsft_checker.sv =====
module bsft_checker import bsft_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item_o
);

  // a waiting word stays until popped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("output word dropped without pop");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(out_item_o))
    else $error("stalled output word changed");

  // the end delimiter always closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.frame_done |-> out_item_o.run_last)
    else $error("frame_done without run_last");

  // a full queue means the serializer already holds a job
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("queue full while serializer idle");

endmodule

bind byte_stuffing_frame_transmitter_core bsft_checker u_bsft_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_item_o (out_item_o)
);

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import bsft_pkg::*;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [CfgIdxW-1:0] IdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] IdxSpareHi = 3'd7;
  localparam cfg_t CfgDefault = '{RstStartByte, RstEndByte, RstEscapeByte,
                                  RstStartSub, RstEndSub, RstEscapeSub};
  localparam int HoldCycles = 150;
  localparam int SettleCycles = 12;
  localparam int StallLimit = 2000;
  localparam int MaxReports = 10;

  typedef struct packed {
    logic [1:0]      op;
    logic [7:0]      val;
    logic            raw;
    logic            typed;
    logic [1:0]      n;
    out_item_t [2:0] res;
  } row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  in_item_t            in_item_i;
  logic                empty;
  logic                pop;
  out_item_t           out_item_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  // framer state as the block should hold it
  cfg_t       cfg_now;
  bit         frame_open;
  logic [6:0] frame_sum;
  bit         frame_raw;

  out_item_t bytes_due[$];
  int        mismatches;
  int        busy_words;
  bit        tx_idle_on;
  bit        rx_idle_on;
  bit        rx_hold_req;

  byte_stuffing_frame_transmitter_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // payload byte, escaped unless the frame runs raw
  function automatic void put_escaped(input logic [7:0] b, inout int n,
                                      inout out_item_t [2:0] res);
    logic [7:0] alt;
    bit         hit;
    hit = 1'b0;
    alt = 8'h00;
    if (!frame_raw) begin
      if (b == cfg_now.start_byte) begin
        hit = 1'b1;
        alt = cfg_now.start_sub;
      end else if (b == cfg_now.end_byte) begin
        hit = 1'b1;
        alt = cfg_now.end_sub;
      end else if (b == cfg_now.escape_byte) begin
        hit = 1'b1;
        alt = cfg_now.escape_sub;
      end
    end
    if (hit) begin
      res[n] = '{cfg_now.escape_byte, 1'b0, 1'b0};
      res[n+1] = '{alt, 1'b0, 1'b0};
      n += 2;
    end else begin
      res[n] = '{b, 1'b0, 1'b0};
      n += 1;
    end
  endfunction

  function automatic void encode_word(input in_item_t w, output int n,
                                      output out_item_t [2:0] res);
    n = 0;
    res = '0;
    case (w.operation)
      OP_START: begin
        frame_open = 1'b1;
        frame_raw = w.raw_mode;
        frame_sum = w.value[6:0];
        res[0] = '{cfg_now.start_byte, 1'b0, 1'b0};
        n = 1;
        put_escaped(w.value, n, res);
      end
      OP_DATA: begin
        if (frame_open) begin
          frame_sum = frame_sum ^ w.value[6:0];
          put_escaped(w.value, n, res);
        end
      end
      OP_END: begin
        if (frame_open) begin
          put_escaped({1'b0, frame_sum}, n, res);
          res[n] = '{cfg_now.end_byte, 1'b0, 1'b1};
          n += 1;
          frame_open = 1'b0;
        end
      end
      default: ;
    endcase
    if (n > 0) res[n-1].run_last = 1'b1;
  endfunction

  function automatic row_t row(logic [1:0] op, logic [7:0] v, logic raw);
    row_t r;
    r = '0;
    r.op = op;
    r.val = v;
    r.raw = raw;
    return r;
  endfunction

  function automatic row_t row_exp(logic [1:0] op, logic [7:0] v, logic raw, int n,
                                   logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                   logic fin);
    row_t             r;
    logic [2:0][7:0]  bs;
    r = row(op, v, raw);
    bs = {b2, b1, b0};
    r.typed = 1'b1;
    r.n = n[1:0];
    for (int i = 0; i < n; i++) begin
      r.res[i].out_byte = bs[i];
      r.res[i].run_last = (i == n - 1);
      r.res[i].frame_done = fin && (i == n - 1);
    end
    return r;
  endfunction

  // often a delimiter or the escape, so stuffing gets exercised
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return cfg_now.start_byte;
      1: return cfg_now.end_byte;
      2: return cfg_now.escape_byte;
      3: return cfg_now.escape_byte ^ 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.start_byte = 8'($urandom_range(0, 127));
    c.end_byte = 8'($urandom_range(0, 255));
    c.escape_byte = 8'($urandom_range(0, 127));
    c.start_sub = 8'($urandom_range(0, 255));
    c.end_sub = 8'($urandom_range(0, 255));
    c.escape_sub = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: c.end_byte = c.start_byte;
      1: c.escape_byte = c.end_byte;
      default: ;
    endcase
    return c;
  endfunction

  task automatic send_word(input row_t r);
    in_item_t        w;
    int              n;
    out_item_t [2:0] res;
    w.operation = r.op;
    w.value = r.val;
    w.raw_mode = r.raw;
    if (tx_idle_on && $urandom_range(0, 2) == 0) begin
      push <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= w;
    @(negedge clk_i);
    while (full) @(negedge clk_i);
    @(posedge clk_i);
    encode_word(w, n, res);
    if (r.typed) begin
      n = r.n;
      res = r.res;
    end
    for (int i = 0; i < n; i++) bytes_due.push_back(res[i]);
    if (n > 0) busy_words++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_START_BYTE:  cfg_now.start_byte = data;
      REG_END_BYTE:    cfg_now.end_byte = data;
      REG_ESCAPE_BYTE: cfg_now.escape_byte = data;
      REG_START_SUB:   cfg_now.start_sub = data;
      REG_END_SUB:     cfg_now.end_sub = data;
      REG_ESCAPE_SUB:  cfg_now.escape_sub = data;
      default: ;
    endcase
  endtask

  task automatic set_cfg(input cfg_t c);
    write_reg(REG_START_BYTE, c.start_byte);
    write_reg(REG_END_BYTE, c.end_byte);
    write_reg(REG_ESCAPE_BYTE, c.escape_byte);
    write_reg(REG_START_SUB, c.start_sub);
    write_reg(REG_END_SUB, c.end_sub);
    write_reg(REG_ESCAPE_SUB, c.escape_sub);
    // spare indexes must not disturb anything
    write_reg(IdxSpareLo, 8'($urandom_range(0, 255)));
    write_reg(IdxSpareHi, 8'($urandom_range(0, 255)));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (bytes_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic run_frames(input int want);
    int         goal;
    logic [7:0] v;
    logic [7:0] tgt;
    goal = busy_words + want;
    while (busy_words < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(row(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1))));
      end else begin
        send_word(row(OP_START, pick_byte(), $urandom_range(0, 3) == 0));
        repeat ($urandom_range(0, 6))
          send_word(row(OP_DATA, pick_byte(), 1'($urandom_range(0, 1))));
        // steer the checksum onto the low seven bits of a byte from pick_byte, often a delimiter or the escape
        if ($urandom_range(0, 2) == 0) begin
          tgt = pick_byte();
          v = 8'($urandom_range(0, 255));
          v[6:0] = frame_sum ^ tgt[6:0];
          send_word(row(OP_DATA, v, 1'($urandom_range(0, 1))));
        end
        if ($urandom_range(0, 6) != 0)
          send_word(row(OP_END, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))));
      end
    end
  endtask

  // receiver side
  initial begin
    int stall_left;
    stall_left = 0;
    pop <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        stall_left = HoldCycles;
        rx_hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  always @(negedge clk_i) begin
    out_item_t want;
    if (rst_ni && pop && !empty) begin
      if (bytes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected output: byte %02h last %0b done %0b",
                   out_item_o.out_byte, out_item_o.run_last, out_item_o.frame_done);
      end else begin
        want = bytes_due.pop_front();
        if (out_item_o.out_byte !== want.out_byte || out_item_o.run_last !== want.run_last ||
            out_item_o.frame_done !== want.frame_done) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("mismatch: got byte %02h last %0b done %0b, want byte %02h last %0b done %0b",
                     out_item_o.out_byte, out_item_o.run_last, out_item_o.frame_done,
                     want.out_byte, want.run_last, want.frame_done);
        end
      end
    end
  end

  // no word moving on either side for too long means a hang
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(negedge clk_i);
      if ((push && !full) || (pop && !empty)) quiet = 0;
      else quiet++;
    end
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    row_t plan[$];
    cfg_t cfg_plan;
    push <= 1'b0;
    in_item_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_wdata_i <= '0;
    rst_ni <= 1'b0;
    cfg_now = CfgDefault;
    frame_open = 1'b0;
    frame_sum = '0;
    frame_raw = 1'b0;
    mismatches = 0;
    busy_words = 0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_hold_req = 1'b0;

    // outside a frame nothing comes out; then a frame opens and its data bytes get stuffed
    plan.push_back(row_exp(OP_DATA, 8'h55, 1'b0, 0, 8'h00, 8'h00, 8'h00, 1'b0));
    plan.push_back(row_exp(OP_END, 8'h00, 1'b0, 0, 8'h00, 8'h00, 8'h00, 1'b0));
    plan.push_back(row_exp(OpUnused, 8'hff, 1'b1, 0, 8'h00, 8'h00, 8'h00, 1'b0));
    plan.push_back(row_exp(OP_START, 8'h00, 1'b0, 2, 8'h02, 8'h00, 8'h00, 1'b0));
    plan.push_back(row_exp(OP_DATA, 8'hff, 1'b0, 1, 8'hff, 8'h00, 8'h00, 1'b0));
    plan.push_back(row_exp(OP_DATA, 8'h02, 1'b0, 2, 8'h1b, 8'he7, 8'h00, 1'b0));
    plan.push_back(row_exp(OP_DATA, 8'h03, 1'b1, 2, 8'h1b, 8'he8, 8'h00, 1'b0));
    plan.push_back(row_exp(OP_DATA, 8'h1b, 1'b0, 2, 8'h1b, 8'h00, 8'h00, 1'b0));
    plan.push_back(row(OpUnused, 8'h00, 1'b0));
    plan.push_back(row(OP_END, 8'haa, 1'b0));
    // raw frame, then a restart in the middle of it
    plan.push_back(row(OP_START, 8'h80, 1'b1));
    plan.push_back(row(OP_DATA, 8'h02, 1'b0));
    plan.push_back(row(OP_DATA, 8'h03, 1'b0));
    plan.push_back(row(OP_DATA, 8'h1b, 1'b1));
    plan.push_back(row(OP_START, 8'h02, 1'b0));
    plan.push_back(row(OP_DATA, 8'h01, 1'b0));
    plan.push_back(row_exp(OP_END, 8'h00, 1'b0, 3, 8'h1b, 8'he8, 8'h03, 1'b1));
    plan.push_back(row_exp(OP_START, 8'h1b, 1'b0, 3, 8'h02, 8'h1b, 8'h00, 1'b0));
    plan.push_back(row_exp(OP_END, 8'hff, 1'b1, 3, 8'h1b, 8'h00, 8'h03, 1'b1));
    plan.push_back(row(OP_END, 8'h00, 1'b0));
    plan.push_back(row(OP_START, 8'h7f, 1'b1));
    plan.push_back(row(OP_DATA, 8'h7d, 1'b0));
    plan.push_back(row(OP_END, 8'h00, 1'b0));
    plan.push_back(row(OP_START, 8'hff, 1'b0));
    plan.push_back(row(OP_DATA, 8'hff, 1'b0));
    plan.push_back(row(OP_END, 8'h00, 1'b0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) send_word(plan[i]);
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: cfg_plan = '0;
        1: cfg_plan = '1;
        4: cfg_plan = CfgDefault;
        default: cfg_plan = rand_cfg();
      endcase
      set_cfg(cfg_plan);
      tx_idle_on = (p != 0 && p != 2);
      rx_idle_on = (p != 3);
      // long receiver hold while the sender keeps pushing
      if (p == 2) rx_hold_req = 1'b1;
      run_frames(78);
      settle();
    end

    if (mismatches == 0 && bytes_due.size() == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
